// File: hw/rtl/aesctr_pkg.sv
`default_nettype none
package aesctr_pkg;

  localparam int BLK_BYTES = 16;
  localparam logic [3:0] LAST_POS   = 4'd15;
  localparam logic [3:0] LAST_ROUND = 4'd10;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_NONCE    = 2'd2;

  // one queued message byte with its position in the keystream block
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [3:0] pos;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [127:0] key;
    logic [63:0]  nonce;
    logic         wr;
  } cfg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    case (rnd)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aesctr_core.sv
`default_nettype none
module aesctr_core import aesctr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire logic [127:0] blk_in,
  output logic              busy,
  output logic              done,
  output logic [127:0]      blk_out
);

  logic [127:0] st_r, rk_r, rk_nxt, rnd_out;
  logic [3:0]   rnd_r;
  logic         busy_r, done_r;
  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [31:0]  tmp, n0, n1, n2, n3;

  // on-the-fly key schedule, one round key per cycle
  always_comb begin
    tmp = {SBOX[rk_r[23:16]] ^ rcon(rnd_r), SBOX[rk_r[15:8]], SBOX[rk_r[7:0]],
           SBOX[rk_r[31:24]]};
    n0 = rk_r[127:96] ^ tmp;
    n1 = rk_r[95:64] ^ n0;
    n2 = rk_r[63:32] ^ n1;
    n3 = rk_r[31:0] ^ n2;
    rk_nxt = {n0, n1, n2, n3};
  end

  // one round: subbytes, shiftrows, mixcolumns (not in the last), addroundkey
  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = st_r[8*(15-i) +: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = t[4*c]   ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                 ^ xtime(t[4*c] ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                 ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                 ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ (t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3])
                 ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++)
      rnd_out[8*(15-i) +: 8] = ((rnd_r == LAST_ROUND) ? t[i] : m[i])
                               ^ rk_nxt[8*(15-i) +: 8];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r  <= blk_in ^ key;
      rk_r  <= key;
    end else if (busy_r) begin
      st_r  <= rnd_out;
      rk_r  <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        if (rnd_r == LAST_ROUND) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign blk_out = st_r;

endmodule
`default_nettype wire

// File: hw/rtl/aesctr_front.sv
`default_nettype none
module aesctr_front import aesctr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_in,
  input  wire logic       in_last_in,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic [3:0]      pos_r;
  logic            push;

  assign in_stall = (cnt_r == CW'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= '{data: in_data_in, last: in_last_in, pos: pos_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      pos_r <= 4'd0;
    end else begin
      if (push) begin
        wr_r  <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
        pos_r <= in_last_in ? 4'd0 : pos_r + 4'd1;
      end
      if (q_pop) rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !q_pop)      cnt_r <= cnt_r + CW'(1);
      else if (!push && q_pop) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aesctr_back.sv
`default_nettype none
module aesctr_back import aesctr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_data_out,
  output logic            out_last_out
);

  logic [63:0]  ctr_r, pf_ctr_r, eng_ctr_r, tgt;
  logic         open_r, pf_valid_r, stale_r;
  logic [127:0] pf_r, cur_r, blk_in, blk_out;
  logic         core_busy, core_done, start, pf_hit, ks_ok, first;
  logic [7:0]   ks_byte;
  logic         out_valid_r, out_last_r;
  logic [7:0]   out_data_r;

  // counter of the block the next block start will need
  assign tgt    = open_r ? ctr_r + 64'd1 : ctr_r;
  assign pf_hit = pf_valid_r && (pf_ctr_r == ctr_r);
  assign first  = (q_item.pos == 4'd0);
  assign ks_ok  = !first || pf_hit;
  assign q_pop  = q_valid && ks_ok && (!out_valid_r || !out_stall);
  assign start  = !core_busy && !core_done && !(pf_valid_r && pf_ctr_r == tgt);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk_in[8*(15-i) +: 8] = cfg.nonce[8*i +: 8];
      blk_in[8*(7-i) +: 8]  = tgt[8*i +: 8];
    end
  end

  assign ks_byte = first ? pf_r[127:120] : cur_r[{~q_item.pos, 3'b000} +: 8];

  aesctr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .key     (cfg.key),
    .blk_in  (blk_in),
    .busy    (core_busy),
    .done    (core_done),
    .blk_out (blk_out)
  );

  always_ff @(posedge clk) begin
    if (start) eng_ctr_r <= tgt;
    if (core_done) begin
      pf_r     <= blk_out;
      pf_ctr_r <= eng_ctr_r;
    end
    if (q_pop && first) cur_r <= pf_r;
    if (q_pop) begin
      out_data_r <= q_item.data ^ ks_byte;
      out_last_r <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= 64'd0;
      open_r      <= 1'b0;
      pf_valid_r  <= 1'b0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.wr)     stale_r <= 1'b1;
      else if (start) stale_r <= 1'b0;

      if (core_done && !stale_r && !cfg.wr) pf_valid_r <= 1'b1;
      else if (cfg.wr)                      pf_valid_r <= 1'b0;
      else if (q_pop && first)              pf_valid_r <= 1'b0;

      if (q_pop) begin
        if (q_item.last) begin
          ctr_r  <= 64'd0;
          open_r <= 1'b0;
        end else if (q_item.pos == LAST_POS) begin
          ctr_r  <= ctr_r + 64'd1;
          open_r <= 1'b0;
        end else begin
          open_r <= 1'b1;
        end
      end

      if (q_pop)          out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last_out = out_last_r;

endmodule
`default_nettype wire

// File: hw/rtl/aes128_ctr_stream_cipher_unit.sv
`default_nettype none
// aes-128 ctr byte cipher: each beat on the in_ channel carries one message byte and
// gives exactly one beat on the out_ channel, the byte xor its keystream byte (the same
// operation encrypts and decrypts). keystream block n is aes-128 of {nonce as 8
// little-endian bytes, n as 8 little-endian bytes}; n restarts at zero after a beat
// with last set. a front queue takes bytes and tags their block position, the back end
// holds the current keystream block plus one prefetched block made by an iterative
// round unit (one round per cycle, a new block only once the last one is done). steady
// state is one byte per cycle while the receiver does not stall, and an in_ beat is
// registered in the queue and then in the output register on its way out; the first
// block of every message, and the first block after any register write, waits for the
// round unit (longer when the unit is still busy with a prefetch that is no longer
// needed). registers (64-bit apb, byte address 8*i): key_low at 0, key_high at 8,
// nonce at 16; writes are meant for idle periods and apply from the next block
module aes128_ctr_stream_cipher_unit import aesctr_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_in,
  input  wire logic        in_last_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_data_out,
  output logic             out_last_out,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] key_low_r, key_high_r, nonce_r;
  logic        wr_en;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  item_t       q_item;

  // apb register file, no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= 64'd0;
      key_high_r <= 64'd0;
      nonce_r    <= 64'd0;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_NONCE:    nonce_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = key_high_r;
      REG_NONCE:    prdata = nonce_r;
      default:      prdata = 64'd0;
    endcase
  end

  // key byte 0 is the top byte of key_high; any write drops the prefetched block
  assign cfg = '{key: {key_high_r, key_low_r}, nonce: nonce_r, wr: wr_en};

  aesctr_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_in (in_data_in),
    .in_last_in (in_last_in),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  aesctr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_last_out (out_last_out)
  );

endmodule
`default_nettype wire

// File: hw/rtl/aesctr_chk.sv
`default_nettype none
module aesctr_chk import aesctr_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_data_out,
  input wire logic        out_last_out,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [4:0]  paddr,
  input wire logic [63:0] pwdata,
  input wire logic [63:0] prdata,
  input wire logic        pready
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("channels not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled beat dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data_out) && $stable(out_last_out))
    else $error("stalled beat changed");

  a_key_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr[4:3] == REG_KEY_LOW)
    ##1 (paddr[4:3] == REG_KEY_LOW)
    |-> prdata == $past(pwdata))
    else $error("key_low readback mismatch");

endmodule

bind aes128_ctr_stream_cipher_unit aesctr_chk u_chk (.*);
`default_nettype wire

// File: sim/aes128_ctr_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module aes128_ctr_checker import aesctr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_in,
  input  wire logic        in_last_in,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_data_out,
  input  wire logic        out_last_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output int               fail_count,
  output int               pending_count,
  output int               byte_count,
  output int               msg_count,
  output int               wrap_count
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_beat_t;

  logic [63:0] key_lo_q, key_hi_q, nonce_q, blk_ctr;
  logic [3:0]  blk_pos;
  logic [7:0]  ks [16];
  cipher_beat_t cipher_q [$];

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // textbook aes-128 forward cipher on byte arrays (state byte = row + 4*col)
  task automatic aes_block(input logic [127:0] key, input logic [7:0] blk [16],
                           output logic [7:0] res [16]);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, al;
    logic [7:0] rc;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[127 - 8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int r = 0; r < 4; r++) w[r] = rk[(i-1)*4 + r];
      if (i % 4 == 0) begin
        f = w[0];
        w[0] = SBOX[w[1]] ^ rc;
        w[1] = SBOX[w[2]];
        w[2] = SBOX[w[3]];
        w[3] = SBOX[f];
        rc = gmul2(rc);
      end
      for (int r = 0; r < 4; r++) rk[i*4 + r] = rk[(i-4)*4 + r] ^ w[r];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[i] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[rnd*16 + i];
    end
    res = s;
  endtask

  task automatic cipher_byte(input logic [7:0] d, input logic lst);
    logic [7:0] ctr [16];
    cipher_beat_t exp_b;
    if (blk_pos == 4'd0) begin
      for (int i = 0; i < 8; i++) begin
        ctr[i]     = nonce_q[8*i +: 8];
        ctr[8 + i] = blk_ctr[8*i +: 8];
      end
      aes_block({key_hi_q, key_lo_q}, ctr, ks);
    end
    exp_b.data = d ^ ks[blk_pos];
    exp_b.last = lst;
    cipher_q.push_back(exp_b);
    byte_count++;
    if (lst) begin
      msg_count++;
      blk_ctr = '0;
      blk_pos = '0;
    end else if (blk_pos == LAST_POS) begin
      if (blk_ctr == '1) wrap_count++;
      blk_ctr = blk_ctr + 64'd1;
      blk_pos = '0;
    end else begin
      blk_pos = blk_pos + 4'd1;
    end
  endtask

  always @(posedge clk) begin
    cipher_beat_t exp_b;
    if (!rst_n) begin
      key_lo_q = '0; key_hi_q = '0; nonce_q = '0;
      blk_ctr = '0; blk_pos = '0;
      cipher_q.delete();
      fail_count = 0; byte_count = 0; msg_count = 0; wrap_count = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:3])
          REG_KEY_LOW:  key_lo_q = pwdata;
          REG_KEY_HIGH: key_hi_q = pwdata;
          REG_NONCE:    nonce_q  = pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cipher_byte(in_data_in, in_last_in);
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected out beat data=%h last=%b", $time, out_data_out,
                   out_last_out);
        end else begin
          exp_b = cipher_q.pop_front();
          if (out_data_out !== exp_b.data) begin
            fail_count++;
            $display("%0t: data_out expected %h actual %h", $time, exp_b.data, out_data_out);
          end
          if (out_last_out !== exp_b.last) begin
            fail_count++;
            $display("%0t: last_out expected %b actual %b", $time, exp_b.last, out_last_out);
          end
        end
      end
    end
    pending_count = cipher_q.size();
  end

endmodule
`default_nettype wire

// File: sim/tb_aes128_ctr_stream_cipher_unit.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_aes128_ctr_stream_cipher_unit import aesctr_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_in = '0;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_last_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count, pending_count, byte_count, msg_count, wrap_count;
  bit quiet_phase = 1'b0;   // no idling on either side
  bit hold_off = 1'b0;      // request for a long receiver stall

  always #5 clk = ~clk;

  aes128_ctr_stream_cipher_unit uut (.*);

  aes128_ctr_checker chk (.*);

  // receiver: random stall about 9 in 100, long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        // count the stretch here so the sender keeps pushing into a full block
        for (n = 0; n < 300; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else begin
        out_stall <= !quiet_phase && ($urandom_range(99) < 9);
      end
    end
  end

  // one register write: setup then access
  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // one byte beat, with random idle cycles before it
  task automatic send_byte(input logic [7:0] d, input logic lst);
    while (!quiet_phase && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data_in <= d; in_last_in <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let the block drain completely before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_keys(input logic [63:0] klo, input logic [63:0] khi,
                          input logic [63:0] nc);
    reg_write(REG_KEY_LOW, klo);
    reg_write(REG_KEY_HIGH, khi);
    reg_write(REG_NONCE, nc);
  endtask

  task automatic rand_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int sent, len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset key, single-byte message, extreme byte values
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();
    // all-ones registers, message crossing a block boundary with a partial tail
    set_keys('1, '1, '1);
    for (int i = 0; i < 18; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 17);
    drain();
    // the fips-197 key bytes with the two words of its low half swapped, and a zero nonce
    set_keys(64'h09cf4f3c_abf71588, 64'h2b7e1516_28aed2a6, 64'h0);
    rand_message(16);
    rand_message(3);
    drain();

    // random part: many messages, new settings between phases
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_keys(64'h0, 64'h0, 64'h0);
        1: set_keys('1, 64'h0, 64'h8000_0000_0000_0001);
        default: set_keys(rand64(), rand64(), rand64());
      endcase
      quiet_phase = (ph == 3);
      if (ph == 5) hold_off = 1'b1;
      for (int m = 0; m < 12; m++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 20);
        rand_message(len);
        sent += len;
      end
      // a single-byte message is added here at random before the phase ends
      if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b1);
      end_burst();
      drain();
    end
    quiet_phase = 1'b0;
    while (sent < 1600) begin
      len = $urandom_range(1, 40);
      rand_message(len);
      sent += len;
    end
    drain();

    $display("covered %0d bytes in %0d messages over several key and nonce settings",
             byte_count, msg_count);
    $display("including a long receiver hold-off and block-boundary tails");
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #5ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/aesctr_pkg.sv
hw/rtl/aesctr_core.sv
hw/rtl/aesctr_front.sv
hw/rtl/aesctr_back.sv
hw/rtl/aes128_ctr_stream_cipher_unit.sv
hw/rtl/aesctr_chk.sv
sim/aes128_ctr_checker.sv
sim/tb_aes128_ctr_stream_cipher_unit.sv
